// ----- rtl/gbt_pkg.sv -----
// Shared types and constants for the graph traversal block.
// No dependencies; imported by graph_bfs_dfs_traversal and its testbench.
package gbt_pkg;

  localparam int NODE_W         = 4;
  localparam int NODES_DEF      = 16;
  localparam int MAX_DEGREE_DEF = 8;
  localparam int MAX_OUT        = 16;
  localparam int CNT_W          = $clog2(MAX_OUT + 1);

  localparam logic [1:0] MODE_EDGE = 2'd0;
  localparam logic [1:0] MODE_BFS  = 2'd1;
  localparam logic [1:0] MODE_DFS  = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;
  } req_t;

  typedef struct packed {
    logic [NODE_W-1:0] visited_node;
    logic              last_of_run;
    logic              status;
  } res_t;

endpackage

// ----- rtl/gbt_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/gbt_alu.sv -----
// Shared add-and-compare unit used by the traversal sequencer.
// No dependencies; width set by the top level.
module gbt_alu #(
  parameter int W = 4
) (
  input  logic [W-1:0] opa,
  input  logic [W-1:0] opb,
  input  logic [W-1:0] lim,
  output logic [W-1:0] sum,
  output logic         less
);

  assign sum  = opa + opb;
  assign less = (sum < lim);

endmodule

// ----- rtl/graph_bfs_dfs_traversal.sv -----
// Undirected graph store with breadth-first / depth-first walks; uses gbt_pkg, gbt_ram, gbt_alu.
// An edge request's single result is registered from S_E_WB (from S_E_CHK on a full list, from
// acceptance on an endpoint beyond the graph); busy is then low, so the next request can follow.
// BFS steps POP, GET, DEG, NB per dequeued node and CHK, NB per stored neighbor; DFS steps TOP,
// DEG, CHK per neighbor and TOP, DEG, POPW per popped node, sharing gbt_alu and RAM reads.
// busy covers each request that leaves idle; results are 1-cycle strobes and cannot be stalled.
// Reset (rst, synchronous) clears control state, degree valid bits and visited marks at once.
module graph_bfs_dfs_traversal
  import gbt_pkg::*;
#(
  parameter int NODES      = NODES_DEF,
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic result_valid,
  output res_t result
);

  // Widths derived from the graph size
  localparam int NIW       = $clog2(NODES);                           // node index
  localparam int SW        = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1; // list slot
  localparam int DW        = $clog2(MAX_DEGREE + 1);                  // degree count
  localparam int PW        = $clog2(NODES + 1);                       // frontier pointer
  localparam int UW        = $clog2(MAX_DEGREE + 3);                  // shared unit width
  localparam int FW        = DW + NODE_W;                             // frontier entry
  localparam int NBR_DEPTH = NODES * (2 ** SW);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_E_RDB  = 4'd1;  // degree of first endpoint back, read second
  localparam logic [3:0] S_E_CHK  = 4'd2;  // room check on both lists
  localparam logic [3:0] S_E_WA   = 4'd3;  // append to first endpoint's list
  localparam logic [3:0] S_E_WB   = 4'd4;  // append to second endpoint's list
  localparam logic [3:0] S_B_POP  = 4'd5;  // dequeue
  localparam logic [3:0] S_B_GET  = 4'd6;  // dequeued node arrives, emit it
  localparam logic [3:0] S_B_DEG  = 4'd7;  // its degree arrives
  localparam logic [3:0] S_B_NB   = 4'd8;  // next neighbor read
  localparam logic [3:0] S_B_CHK  = 4'd9;  // neighbor arrives, enqueue if new
  localparam logic [3:0] S_D_TOP  = 4'd10; // read degree of stack top
  localparam logic [3:0] S_D_DEG  = 4'd11; // advance resume index or pop
  localparam logic [3:0] S_D_CHK  = 4'd12; // neighbor arrives, push if new
  localparam logic [3:0] S_D_POPW = 4'd13; // new top arrives from the stack RAM
  localparam logic [3:0] S_FLUSH  = 4'd14; // emit held result with last flag

  logic [3:0]        state;

  // Request registers
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  logic              self_loop;
  logic [DW-1:0]     dega;
  logic [DW-1:0]     degb;
  logic              room_a;

  // Traversal registers (cur_v / idx are also the cached DFS stack top)
  logic [NODE_W-1:0] cur_v;
  logic [DW-1:0]     idx;
  logic [DW-1:0]     cur_deg;
  logic [PW-1:0]     head;
  logic [PW-1:0]     tail;
  logic [CNT_W-1:0]  count;
  logic [NODES-1:0]  visited;

  // Degree valid bits: unwritten entries read as zero
  logic [NODES-1:0]  deg_vld;
  logic              deg_rd_vld;

  // One result is held back until we know whether it is the last one
  logic              pend_vld;
  logic [NODE_W-1:0] pend_node;

  // Result register inputs
  logic              result_valid_next;
  res_t              result_next;

  // RAM ports
  logic              deg_we;
  logic [NIW-1:0]    deg_waddr;
  logic [DW-1:0]     deg_wdata;
  logic [NIW-1:0]    deg_raddr;
  logic [DW-1:0]     deg_rdata;
  logic [DW-1:0]     deg_q;

  logic              nbr_we;
  logic [NIW+SW-1:0] nbr_waddr;
  logic [NODE_W-1:0] nbr_wdata;
  logic [NIW+SW-1:0] nbr_raddr;
  logic [NODE_W-1:0] nbr_rdata;

  logic              fr_we;
  logic [NIW-1:0]    fr_waddr;
  logic [FW-1:0]     fr_wdata;
  logic [NIW-1:0]    fr_raddr;
  logic [FW-1:0]     fr_rdata;

  // Shared unit
  logic [UW-1:0]     alu_opa;
  logic [UW-1:0]     alu_opb;
  logic [UW-1:0]     alu_lim;
  logic [UW-1:0]     alu_sum;
  logic              alu_less;

  logic              accept;
  logic              start_ok;
  logic              range_ok;
  logic              room_ok;
  logic [NIW-1:0]    w_idx;
  logic              new_ok;
  logic              push;
  logic [NODE_W-1:0] push_node;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign start_ok = int'(request.first_node) < NODES;
  assign range_ok = start_ok && (int'(request.second_node) < NODES);
  assign room_ok  = room_a && (self_loop || alu_less);
  assign deg_q    = deg_rd_vld ? deg_rdata : '0;
  assign w_idx    = NIW'(nbr_rdata);

  // Neighbor is taken when unseen and the frontier has room; DFS also caps the result count
  always_comb begin
    new_ok = !visited[w_idx] && (tail < PW'(NODES));
    if (state == S_D_CHK) begin
      new_ok = new_ok && (count < CNT_W'(MAX_OUT));
    end
  end

  // Emitted-node event
  always_comb begin
    push      = 1'b0;
    push_node = request.first_node;
    if (state == S_B_GET) begin
      push      = 1'b1;
      push_node = fr_rdata[NODE_W-1:0];
    end else if (state == S_D_CHK) begin
      push      = new_ok;
      push_node = nbr_rdata;
    end else if (accept && (request.mode == MODE_DFS) && start_ok) begin
      push      = 1'b1;
    end
  end

  // Result strobe: a held node handed on, the final flush, or an edge verdict
  always_comb begin
    result_valid_next = 1'b0;
    result_next       = result;
    if (push && pend_vld) begin
      result_valid_next = 1'b1;
      result_next       = '{visited_node: pend_node, last_of_run: 1'b0, status: 1'b0};
    end else if ((state == S_FLUSH) && pend_vld) begin
      result_valid_next = 1'b1;
      result_next       = '{visited_node: pend_node, last_of_run: 1'b1, status: 1'b0};
    end else if (accept && (request.mode == MODE_EDGE) && !range_ok) begin
      result_valid_next = 1'b1;
      result_next       = '{visited_node: '0, last_of_run: 1'b1, status: 1'b1};
    end else if ((state == S_E_CHK) && !room_ok) begin
      result_valid_next = 1'b1;
      result_next       = '{visited_node: '0, last_of_run: 1'b1, status: 1'b1};
    end else if (state == S_E_WB) begin
      result_valid_next = 1'b1;
      result_next       = '{visited_node: '0, last_of_run: 1'b1, status: 1'b0};
    end
  end

  // Shared unit operands
  always_comb begin
    alu_opa = '0;
    alu_opb = '0;
    alu_lim = UW'(MAX_DEGREE + 1);
    unique case (state)
      S_E_RDB: begin
        alu_opa = UW'(deg_q);
        alu_opb = self_loop ? UW'(2) : UW'(1);
      end
      S_E_CHK: begin
        alu_opa = UW'(deg_q);
        alu_opb = UW'(1);
      end
      S_E_WA: begin
        alu_opa = UW'(dega);
        alu_opb = UW'(1);
      end
      S_E_WB: begin
        alu_opa = UW'(degb);
        alu_opb = UW'(1);
      end
      S_B_NB: begin
        alu_opa = UW'(idx);
        alu_lim = UW'(cur_deg);
      end
      S_D_DEG: begin
        alu_opa = UW'(idx);
        alu_lim = UW'(deg_q);
      end
      default: begin
        alu_opa = '0;
      end
    endcase
  end

  // Memory port control
  always_comb begin
    deg_we    = 1'b0;
    deg_waddr = NIW'(node_a);
    deg_wdata = DW'(alu_sum);
    nbr_we    = 1'b0;
    nbr_waddr = {NIW'(node_a), dega[SW-1:0]};
    nbr_wdata = node_b;
    fr_we     = 1'b0;
    fr_waddr  = tail[NIW-1:0];
    fr_wdata  = {{DW{1'b0}}, nbr_rdata};
    unique case (state)
      S_IDLE:  deg_raddr = NIW'(request.first_node);
      S_E_RDB: deg_raddr = NIW'(node_b);
      S_B_GET: deg_raddr = NIW'(fr_rdata[NODE_W-1:0]);
      default: deg_raddr = NIW'(cur_v);
    endcase
    unique case (state)
      S_IDLE: begin
        // BFS seeds the queue with the start node
        fr_we    = accept && (request.mode == MODE_BFS) && start_ok;
        fr_waddr = '0;
        fr_wdata = {{DW{1'b0}}, request.first_node};
      end
      S_E_WA: begin
        deg_we = 1'b1;
        nbr_we = 1'b1;
      end
      S_E_WB: begin
        deg_we    = 1'b1;
        deg_waddr = NIW'(node_b);
        nbr_we    = 1'b1;
        nbr_waddr = {NIW'(node_b), degb[SW-1:0]};
        nbr_wdata = node_a;
      end
      S_B_CHK: begin
        fr_we = new_ok;
      end
      S_D_CHK: begin
        // spill the current top (with advanced resume index) below the new one
        fr_we    = new_ok;
        fr_waddr = NIW'(tail - PW'(1));
        fr_wdata = {idx, cur_v};
      end
      default: begin
        fr_we = 1'b0;
      end
    endcase
  end

  assign nbr_raddr = {NIW'(cur_v), idx[SW-1:0]};
  assign fr_raddr  = (state == S_B_POP) ? head[NIW-1:0] : NIW'(tail - PW'(2));

  gbt_ram #(.WIDTH(DW), .DEPTH(NODES)) u_deg (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  gbt_ram #(.WIDTH(NODE_W), .DEPTH(NBR_DEPTH)) u_nbr (
    .clk   (clk),
    .we    (nbr_we),
    .waddr (nbr_waddr),
    .wdata (nbr_wdata),
    .raddr (nbr_raddr),
    .rdata (nbr_rdata)
  );

  gbt_ram #(.WIDTH(FW), .DEPTH(NODES)) u_frontier (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  gbt_alu #(.W(UW)) u_alu (
    .opa  (alu_opa),
    .opb  (alu_opb),
    .lim  (alu_lim),
    .sum  (alu_sum),
    .less (alu_less)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pend_vld     <= 1'b0;
      result_valid <= 1'b0;
      deg_vld      <= '0;
      visited      <= '0;
      head         <= '0;
      tail         <= '0;
      count        <= '0;
    end else begin
      result_valid <= result_valid_next;
      result       <= result_next;
      deg_rd_vld   <= deg_vld[deg_raddr];
      if (deg_we) begin
        deg_vld[deg_waddr] <= 1'b1;
      end
      if (push) begin
        pend_node <= push_node;
        pend_vld  <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (request.mode)
              MODE_EDGE: begin
                node_a    <= request.first_node;
                node_b    <= request.second_node;
                self_loop <= (request.first_node == request.second_node);
                if (range_ok) begin
                  state <= S_E_RDB;
                end
              end
              MODE_BFS: begin
                if (start_ok) begin
                  // fresh marks with only the start node seen
                  visited <= NODES'(1) << request.first_node;
                  head    <= '0;
                  tail    <= PW'(1);
                  count   <= '0;
                  state   <= S_B_POP;
                end
              end
              MODE_DFS: begin
                if (start_ok) begin
                  visited <= NODES'(1) << request.first_node;
                  cur_v   <= request.first_node;
                  idx     <= '0;
                  tail    <= PW'(1);
                  count   <= CNT_W'(1);
                  state   <= S_D_TOP;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_E_RDB: begin
          dega   <= deg_q;
          room_a <= alu_less;
          state  <= S_E_CHK;
        end
        S_E_CHK: begin
          if (room_ok) begin
            degb  <= deg_q;
            state <= S_E_WA;
          end else begin
            state <= S_IDLE;
          end
        end
        S_E_WA: begin
          // self loop: second append lands after the first
          if (self_loop) begin
            degb <= DW'(alu_sum);
          end
          state <= S_E_WB;
        end
        S_E_WB: begin
          state <= S_IDLE;
        end
        S_B_POP: begin
          if ((head < tail) && (count < CNT_W'(MAX_OUT))) begin
            head  <= head + PW'(1);
            state <= S_B_GET;
          end else begin
            state <= S_FLUSH;
          end
        end
        S_B_GET: begin
          cur_v <= fr_rdata[NODE_W-1:0];
          count <= count + CNT_W'(1);
          state <= S_B_DEG;
        end
        S_B_DEG: begin
          cur_deg <= deg_q;
          idx     <= '0;
          state   <= S_B_NB;
        end
        S_B_NB: begin
          if (alu_less) begin
            idx   <= idx + DW'(1);
            state <= S_B_CHK;
          end else begin
            state <= S_B_POP;
          end
        end
        S_B_CHK: begin
          if (new_ok) begin
            visited[w_idx] <= 1'b1;
            tail           <= tail + PW'(1);
          end
          state <= S_B_NB;
        end
        S_D_TOP: begin
          state <= S_D_DEG;
        end
        S_D_DEG: begin
          if (alu_less) begin
            idx   <= idx + DW'(1);
            state <= S_D_CHK;
          end else begin
            tail <= tail - PW'(1);
            if (tail == PW'(1)) begin
              state <= S_FLUSH;
            end else begin
              state <= S_D_POPW;
            end
          end
        end
        S_D_CHK: begin
          if (new_ok) begin
            visited[w_idx] <= 1'b1;
            count          <= count + CNT_W'(1);
            tail           <= tail + PW'(1);
            cur_v          <= nbr_rdata;
            idx            <= '0;
          end
          state <= S_D_TOP;
        end
        S_D_POPW: begin
          cur_v <= fr_rdata[NODE_W-1:0];
          idx   <= fr_rdata[FW-1:NODE_W];
          state <= S_D_TOP;
        end
        S_FLUSH: begin
          pend_vld <= 1'b0;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A rejected edge is always the only, and so last, result
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status |-> result.last_of_run)
    else $error("rejected edge result without last flag");

  // No held-back result may survive into idle
  a_no_pending_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !pend_vld)
    else $error("pending result left when idle");

  // Frontier never exceeds the node count
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= PW'(NODES))
    else $error("frontier pointer out of range");

  // Flush always returns to idle
  a_flush_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |=> !busy)
    else $error("flush did not end the request");

endmodule

// ----- tb/tb_graph_bfs_dfs_traversal.sv -----
// Self-checking testbench for graph_bfs_dfs_traversal: edge loads, breadth-first and
// depth-first walks, checked result by result against an in-bench graph model.
// Depends on rtl/gbt_pkg.sv and the block's RTL; needs no files or arguments.
module tb_graph_bfs_dfs_traversal
  import gbt_pkg::*;
;

  localparam int NODES       = NODES_DEF;
  localparam int MAX_DEGREE  = MAX_DEGREE_DEF;
  localparam int RAND_ITEMS  = 175;
  localparam int SETTLE      = 60;       // quiet cycles after the last expected result
  localparam int CYCLE_LIMIT = 400_000;  // far above the slowest legal run
  localparam int IDLE_PCT    = 38;
  // The block ignores the fourth mode code; the package does not name it.
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  // Graph model: adjacency lists, visited marks and the queue of expected results.
  class graph_model;
    logic [NODE_W-1:0] adj [NODES][MAX_DEGREE];
    int unsigned       degree [NODES];
    bit                seen [NODES];
    res_t              expected_q [$];
    int failures, checked, edges_ok, edges_refused, bfs_runs, dfs_runs, ignored;

    function automatic res_t visit(logic [NODE_W-1:0] node);
      res_t r;
      r.visited_node = node;
      r.last_of_run  = 1'b0;
      r.status       = 1'b0;
      return r;
    endfunction

    // Both endpoints get each other in arrival order; a self loop lands twice.
    function void load_edge(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
      bit   ok;
      res_t r;
      if (a == b) ok = (degree[a] + 2 <= MAX_DEGREE);
      else        ok = (degree[a] < MAX_DEGREE) && (degree[b] < MAX_DEGREE);
      if (ok) begin
        adj[a][degree[a]] = b;
        degree[a]++;
        adj[b][degree[b]] = a;
        degree[b]++;
        edges_ok++;
      end else begin
        edges_refused++;
      end
      r.visited_node = '0;
      r.last_of_run  = 1'b1;
      r.status       = !ok;
      expected_q = {expected_q, r};
    endfunction

    function void walk_bfs(logic [NODE_W-1:0] s, ref res_t walk[$]);
      logic [NODE_W-1:0] fifo [$];
      logic [NODE_W-1:0] v, w;
      int pushes;
      seen[s] = 1'b1;
      fifo = {fifo, s};
      pushes = 1;
      while (fifo.size() > 0 && walk.size() < MAX_OUT) begin
        v = fifo.pop_front();
        walk = {walk, visit(v)};
        for (int i = 0; i < degree[v]; i++) begin
          w = adj[v][i];
          if (!seen[w] && pushes < NODES) begin
            seen[w] = 1'b1;
            fifo = {fifo, w};
            pushes++;
          end
        end
      end
    endfunction

    // Explicit stack of (node, next neighbor index), same order as recursion.
    function void walk_dfs(logic [NODE_W-1:0] s, ref res_t walk[$]);
      logic [NODE_W-1:0] stk_node [NODES];
      int unsigned       stk_idx  [NODES];
      logic [NODE_W-1:0] v, w;
      int depth;
      seen[s] = 1'b1;
      walk = {walk, visit(s)};
      stk_node[0] = s;
      stk_idx[0]  = 0;
      depth = 1;
      while (depth > 0) begin
        v = stk_node[depth-1];
        if (stk_idx[depth-1] < degree[v]) begin
          w = adj[v][stk_idx[depth-1]];
          stk_idx[depth-1]++;
          if (!seen[w] && depth < NODES && walk.size() < MAX_OUT) begin
            seen[w] = 1'b1;
            walk = {walk, visit(w)};
            stk_node[depth] = w;
            stk_idx[depth]  = 0;
            depth++;
          end
        end else begin
          depth--;
        end
      end
    endfunction

    // Called for every accepted request.
    function void note_request(req_t q);
      res_t walk [$];
      if (q.mode == MODE_EDGE) begin
        load_edge(q.first_node, q.second_node);
      end else if (q.mode == MODE_IGNORED) begin
        ignored++;
      end else begin
        foreach (seen[i]) seen[i] = 1'b0;
        if (q.mode == MODE_BFS) begin
          walk_bfs(q.first_node, walk);
          bfs_runs++;
        end else begin
          walk_dfs(q.first_node, walk);
          dfs_runs++;
        end
        if (walk.size() > 0) walk[walk.size()-1].last_of_run = 1'b1;
        expected_q = {expected_q, walk};
      end
    endfunction

    // Called for every result strobe.
    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: visited_node %0d last_of_run %0b status %0b",
               got.visited_node, got.last_of_run, got.status);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.visited_node !== want.visited_node) begin
        $error("visited_node: expected %0d, got %0d", want.visited_node, got.visited_node);
        failures++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0b, got %0b", want.status, got.status);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic result_valid;
  res_t result;

  graph_model model = new();
  int unsigned cycles;
  bit calm;  // set while the sender must not idle

  graph_bfs_dfs_traversal DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Monitor: results are checked before the same-edge request is noted, since a
  // strobe at that edge can only belong to an earlier request.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) model.check_result(result);
      if (start && !busy) model.note_request(request);
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycles, model.expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Start goes low for an idle step; the request bus carries junk the block must ignore.
  task automatic idle_cycle();
    @(negedge clk);
    start   = 1'b0;
    request = req_t'($urandom);
  endtask

  // Present a request and hold it until the block takes it (busy low at the edge).
  task automatic issue(logic [1:0] mode, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    bit taken;
    while (!calm && $urandom_range(99) < IDLE_PCT) idle_cycle();
    @(negedge clk);
    start               = 1'b1;
    request.mode        = mode;
    request.first_node  = a;
    request.second_node = b;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
  endtask

  // Hold off until every owed result has come, then let the block settle.
  task automatic drain();
    idle_cycle();
    while (model.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int sent;
    logic [1:0] m;
    logic [NODE_W-1:0] a, b;
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    calm    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part.
    issue(MODE_BFS, 4'd5, 4'd0);       // walk on an empty graph: start node only
    issue(MODE_DFS, 4'd5, 4'd15);
    issue(MODE_IGNORED, 4'd15, 4'd15); // ignored code, no result
    issue(MODE_EDGE, 4'd0, 4'd15);
    issue(MODE_EDGE, 4'd3, 4'd3);      // self loop takes two slots
    // Fill node 15 to its limit, then try one more edge and a self loop on it.
    issue(MODE_EDGE, 4'd15, 4'd1);
    issue(MODE_EDGE, 4'd15, 4'd2);
    issue(MODE_EDGE, 4'd15, 4'd4);
    issue(MODE_EDGE, 4'd15, 4'd5);
    issue(MODE_EDGE, 4'd15, 4'd6);
    issue(MODE_EDGE, 4'd15, 4'd7);
    issue(MODE_EDGE, 4'd15, 4'd8);
    issue(MODE_EDGE, 4'd9, 4'd15);     // full list on the second endpoint
    issue(MODE_EDGE, 4'd15, 4'd15);
    // Node 3 up to seven entries: a self loop no longer fits, a plain edge still does.
    issue(MODE_EDGE, 4'd3, 4'd3);
    issue(MODE_EDGE, 4'd3, 4'd3);
    issue(MODE_EDGE, 4'd3, 4'd10);
    issue(MODE_EDGE, 4'd3, 4'd3);
    issue(MODE_EDGE, 4'd3, 4'd11);
    issue(MODE_BFS, 4'd15, 4'd0);
    issue(MODE_DFS, 4'd15, 4'd0);
    issue(MODE_DFS, 4'd3, 4'd0);
    issue(MODE_BFS, 4'd0, 4'd15);
    drain();

    // Random part: half the draws are edges so walks see the graph grow; ignored codes
    // are mixed in but do not count.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(99)) inside
        [0:49]:  m = MODE_EDGE;
        [50:71]: m = MODE_BFS;
        [72:93]: m = MODE_DFS;
        default: m = MODE_IGNORED;
      endcase
      a = NODE_W'($urandom_range(NODES - 1));
      b = NODE_W'($urandom_range(NODES - 1));
      if (m == MODE_EDGE && $urandom_range(9) == 0) b = a;
      calm = (sent >= 120 && sent < 170);  // back-to-back stretch
      issue(m, a, b);
      if (m != MODE_IGNORED) sent++;
      if (sent == 100 && m != MODE_IGNORED) drain();
    end
    calm = 1'b0;

    drain();
    $display("Ran %0d edge loads (%0d stored, %0d refused) plus %0d ignored codes.",
             model.edges_ok + model.edges_refused, model.edges_ok, model.edges_refused,
             model.ignored);
    $display("Walked %0d breadth-first and %0d depth-first; %0d results compared.",
             model.bfs_runs, model.dfs_runs, model.checked);
    if (model.failures == 0 && model.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/gbt_pkg.sv
rtl/gbt_ram.sv
rtl/gbt_alu.sv
rtl/graph_bfs_dfs_traversal.sv
tb/tb_graph_bfs_dfs_traversal.sv
